### rtl/bdsmp_pkg.sv
package bdsmp_pkg;

  localparam int STEP  = 1000;
  localparam int NODES = 10;
  localparam int BANDS = 3;

  localparam int IDX_W  = 4;
  localparam int FRAC_W = 10;
  localparam int COEF_W = 8;
  localparam int PROD_W = 18;
  localparam int CORR_W = 20;
  localparam int CLS_W  = 2;

  localparam logic [0:0] REG_IGSO_MASK = 1'd0;
  localparam logic [0:0] REG_MEO_MASK  = 1'd1;

  localparam logic [CLS_W-1:0] CLS_OTHER = 2'd0;
  localparam logic [CLS_W-1:0] CLS_IGSO  = 2'd1;
  localparam logic [CLS_W-1:0] CLS_MEO   = 2'd2;

  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic signed [PROD_W-1:0] band_val_t;

  // centimetres, [band][10-degree node]
  localparam coef_t IGSO_TAB [BANDS][NODES] = '{
    '{-8'sd55, -8'sd40, -8'sd34, -8'sd23, -8'sd15, -8'sd4, 8'sd9, 8'sd19, 8'sd27, 8'sd35},
    '{-8'sd71, -8'sd36, -8'sd33, -8'sd19, -8'sd14, -8'sd3, 8'sd8, 8'sd17, 8'sd24, 8'sd33},
    '{-8'sd27, -8'sd23, -8'sd21, -8'sd15, -8'sd11, -8'sd4, 8'sd5, 8'sd14, 8'sd19, 8'sd32}
  };
  localparam coef_t MEO_TAB [BANDS][NODES] = '{
    '{-8'sd47, -8'sd38, -8'sd32, -8'sd23, -8'sd11, 8'sd6, 8'sd34, 8'sd69, 8'sd97, 8'sd105},
    '{-8'sd40, -8'sd31, -8'sd26, -8'sd18, -8'sd6, 8'sd9, 8'sd28, 8'sd48, 8'sd64, 8'sd69},
    '{-8'sd22, -8'sd15, -8'sd13, -8'sd10, -8'sd4, 8'sd5, 8'sd14, 8'sd27, 8'sd36, 8'sd47}
  };

  typedef struct packed {
    logic               meo;
    logic [IDX_W-1:0]   idx;
    logic [FRAC_W-1:0]  frac;
    logic [BANDS-1:0]   bands;
    logic [CLS_W-1:0]   cls;
  } dec_t;

endpackage

### rtl/bdsmp_decode.sv
module bdsmp_decode (
  input  logic               clk,
  input  logic               en,
  input  logic [5:0]         prn,
  input  logic signed [14:0] elevation,
  input  logic [2:0]         band_present,
  input  logic [63:0]        igso_mask,
  input  logic [63:0]        meo_mask,
  output bdsmp_pkg::dec_t    dec_r
);

  bdsmp_pkg::dec_t dec_nxt;
  logic [13:0]     emag;
  logic [13:0]     rem;
  logic [3:0]      idx;

  always_comb begin
    emag = elevation[13:0];
    idx  = 4'd0;
    for (int k = 1; k < bdsmp_pkg::NODES - 1; k++) begin
      if (emag >= 14'(k * bdsmp_pkg::STEP)) begin
        idx = 4'(k);
      end
    end
    rem = emag - 14'(idx) * 14'(bdsmp_pkg::STEP);

    dec_nxt = '0;
    if (igso_mask[prn]) begin
      dec_nxt.cls = bdsmp_pkg::CLS_IGSO;
    end else if (meo_mask[prn]) begin
      dec_nxt.cls = bdsmp_pkg::CLS_MEO;
    end else begin
      dec_nxt.cls = bdsmp_pkg::CLS_OTHER;
    end
    dec_nxt.meo   = (dec_nxt.cls == bdsmp_pkg::CLS_MEO);
    dec_nxt.bands = (dec_nxt.cls == bdsmp_pkg::CLS_OTHER) ? 3'd0 : band_present;

    if (elevation[14]) begin
      dec_nxt.idx  = 4'd0;
      dec_nxt.frac = 10'd0;
    end else if (emag >= 14'((bdsmp_pkg::NODES - 1) * bdsmp_pkg::STEP)) begin
      // top clamp: last segment at full weight on the last node
      dec_nxt.idx  = 4'(bdsmp_pkg::NODES - 2);
      dec_nxt.frac = 10'(bdsmp_pkg::STEP);
    end else begin
      dec_nxt.idx  = idx;
      dec_nxt.frac = rem[9:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dec_r <= dec_nxt;
    end
  end

endmodule

### rtl/bdsmp_lanes.sv
module bdsmp_lanes (
  input  logic                 clk,
  input  logic                 en_mul,
  input  logic                 en_add,
  input  bdsmp_pkg::dec_t      dec,
  output bdsmp_pkg::band_val_t val_r [bdsmp_pkg::BANDS]
);

  bdsmp_pkg::band_val_t p0_r   [bdsmp_pkg::BANDS];
  bdsmp_pkg::band_val_t p1_r   [bdsmp_pkg::BANDS];
  bdsmp_pkg::band_val_t p0_nxt [bdsmp_pkg::BANDS];
  bdsmp_pkg::band_val_t p1_nxt [bdsmp_pkg::BANDS];
  bdsmp_pkg::band_val_t val_nxt [bdsmp_pkg::BANDS];
  bdsmp_pkg::coef_t     c0, c1;
  logic [bdsmp_pkg::BANDS-1:0] bands_r;
  logic [3:0]           idx1;
  logic [9:0]           w0;
  logic [18:0]          s;

  always_comb begin
    idx1 = dec.idx + 4'd1;
    w0   = 10'(bdsmp_pkg::STEP) - dec.frac;
    c0   = '0;
    c1   = '0;
    for (int b = 0; b < bdsmp_pkg::BANDS; b++) begin
      c0 = dec.meo ? bdsmp_pkg::MEO_TAB[b][dec.idx] : bdsmp_pkg::IGSO_TAB[b][dec.idx];
      c1 = dec.meo ? bdsmp_pkg::MEO_TAB[b][idx1]    : bdsmp_pkg::IGSO_TAB[b][idx1];
      p0_nxt[b] = 18'(c0) * 18'($signed({1'b0, w0}));
      p1_nxt[b] = 18'(c1) * 18'($signed({1'b0, dec.frac}));
    end
  end

  always_comb begin
    s = '0;
    for (int b = 0; b < bdsmp_pkg::BANDS; b++) begin
      s = 19'(p0_r[b]) + 19'(p1_r[b]);
      val_nxt[b] = bands_r[b] ? s[17:0] : 18'sd0;
    end
  end

  always_ff @(posedge clk) begin
    if (en_mul) begin
      p0_r    <= p0_nxt;
      p1_r    <= p1_nxt;
      bands_r <= dec.bands;
    end
    if (en_add) begin
      val_r <= val_nxt;
    end
  end

endmodule

### rtl/bdsmp_sum.sv
module bdsmp_sum (
  input  logic                 clk,
  input  logic                 en,
  input  bdsmp_pkg::band_val_t val [bdsmp_pkg::BANDS],
  input  logic [1:0]           cls,
  output logic signed [19:0]   correction_r,
  output logic [1:0]           sat_class_r
);

  logic signed [19:0] correction_nxt;

  always_comb begin
    correction_nxt = 20'sd0;
    for (int b = 0; b < bdsmp_pkg::BANDS; b++) begin
      correction_nxt = correction_nxt - 20'(val[b]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      correction_r <= correction_nxt;
      sat_class_r  <= cls;
    end
  end

endmodule

### rtl/bds2_code_multipath_correction_unit.sv
// BDS-2 satellite-induced code multipath correction.
// Input words on in_*: PRN, elevation (0.01 deg) and band-present flags.
// Each input word yields exactly one output word on out_*: the negative
// summed correction in 1e-5 m, with the satellite class on out_tuser
// (0 other, 1 IGSO, 2 MEO). Unclassified PRNs give zero.
// cfg_we/cfg_addr/cfg_wdata write the IGSO mask (index 0) or MEO mask
// (index 1); write only while no words are in flight.
// Pipeline: decode, table lookup and multiply, band add, sum into the
// output register, which drives out_tvalid.
// Throughput is one word per cycle while out_tready is high; every stage carries its own valid
// bit, so bubbles are squeezed out.
// Synchronous reset clears both masks and all valid bits.
// When the receiver holds out_tready low the output word is held and the
// stages behind it keep filling; in_tready drops only once all four
// stages hold words.
module bds2_code_multipath_correction_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // prn[5:0], elevation[20:6], band_present[23:21]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // correction[19:0], zero[23:20]
  output logic [1:0]  out_tuser,  // sat_class[1:0]
  input  logic        cfg_we,
  input  logic [0:0]  cfg_addr,
  input  logic [63:0] cfg_wdata
);

  logic [63:0] igso_mask_r, meo_mask_r;
  logic        v1_r, v2_r, v3_r, ov_r;
  logic        rdy1, rdy2, rdy3, rdy4;
  logic [1:0]  cls2_r, cls3_r;
  logic signed [19:0] correction;
  logic [1:0]  sat_class;

  bdsmp_pkg::dec_t      dec_r;
  bdsmp_pkg::band_val_t val [bdsmp_pkg::BANDS];

  assign rdy4 = !ov_r || out_tready;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;
  assign in_tready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      igso_mask_r <= '0;
      meo_mask_r  <= '0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      ov_r        <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          bdsmp_pkg::REG_IGSO_MASK: igso_mask_r <= cfg_wdata;
          bdsmp_pkg::REG_MEO_MASK:  meo_mask_r  <= cfg_wdata;
          default: ;
        endcase
      end
      if (rdy1) v1_r <= in_tvalid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) ov_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2) cls2_r <= dec_r.cls;
    if (rdy3) cls3_r <= cls2_r;
  end

  bdsmp_decode u_decode (
    .clk          (clk),
    .en           (rdy1),
    .prn          (in_tdata[5:0]),
    .elevation    ($signed(in_tdata[20:6])),
    .band_present (in_tdata[23:21]),
    .igso_mask    (igso_mask_r),
    .meo_mask     (meo_mask_r),
    .dec_r        (dec_r)
  );

  bdsmp_lanes u_lanes (
    .clk    (clk),
    .en_mul (rdy2),
    .en_add (rdy3),
    .dec    (dec_r),
    .val_r  (val)
  );

  bdsmp_sum u_sum (
    .clk          (clk),
    .en           (rdy4),
    .val          (val),
    .cls          (cls3_r),
    .correction_r (correction),
    .sat_class_r  (sat_class)
  );

  assign out_tvalid = ov_r;
  assign out_tdata  = {4'd0, correction};
  assign out_tuser  = sat_class;

endmodule

### rtl/bdsmp_checker.sv
module bdsmp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic [1:0]  out_tuser
);

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled output word changed");

  a_class_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser != 2'd3)
    else $error("bad satellite class");

  a_other_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == bdsmp_pkg::CLS_OTHER |-> out_tdata == 24'd0)
    else $error("unclassified satellite with nonzero correction");

  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input blocked with empty output");

endmodule

bind bds2_code_multipath_correction_unit bdsmp_checker u_bdsmp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

### tb/sv/bds2_code_multipath_correction_unit_tb.sv
`timescale 1ns / 100ps

module bds2_code_multipath_correction_unit_tb;

  localparam int CLK_HALF   = 4;
  localparam int MAX_CYCLES = 200000;
  localparam int HOLD_LEN   = 300;
  localparam int DRAIN_WAIT = 8;

  localparam logic [63:0] BDS2_IGSO = 64'h0000_0000_0001_23C0; // 6-9, 13, 16
  localparam logic [63:0] BDS2_MEO  = 64'h0000_0000_0000_5800; // 11, 12, 14

  // coefficients in cm, [band][10-degree node]
  localparam int IGSO_CM [3][10] = '{
    '{-55, -40, -34, -23, -15, -4, 9, 19, 27, 35},
    '{-71, -36, -33, -19, -14, -3, 8, 17, 24, 33},
    '{-27, -23, -21, -15, -11, -4, 5, 14, 19, 32}
  };
  localparam int MEO_CM [3][10] = '{
    '{-47, -38, -32, -23, -11, 6, 34, 69, 97, 105},
    '{-40, -31, -26, -18, -6, 9, 28, 48, 64, 69},
    '{-22, -15, -13, -10, -4, 5, 14, 27, 36, 47}
  };

  typedef struct {
    logic signed [bdsmp_pkg::CORR_W-1:0] corr;
    logic [bdsmp_pkg::CLS_W-1:0]         cls;
  } mp_word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;   // prn[5:0], elevation[20:6], band_present[23:21]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;       // correction[19:0], zero[23:20]
  logic [1:0]  out_tuser;       // sat_class[1:0]
  logic        cfg_we = 1'b0;
  logic [0:0]  cfg_addr = '0;
  logic [63:0] cfg_wdata = '0;

  logic [63:0] igso_mask = '0;
  logic [63:0] meo_mask = '0;
  mp_word_t    pending_corr_q[$];

  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  bit hold_req = 0;
  int hold_cnt = 0;
  int cycle_cnt = 0;
  int words_sent = 0;
  int words_checked = 0;
  int errors = 0;

  bds2_code_multipath_correction_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > MAX_CYCLES) begin
      $display("%0t timeout after %0d cycles", $time, cycle_cnt);
      $display("FAIL");
      $finish;
    end
  end

  // one band at elevation e (0.01 deg), in 1e-5 m
  function automatic int band_term(input int b, input bit is_meo, input int e);
    int idx;
    int frac;
    int nxt;
    int c0;
    int c1;
    if (e < 0) begin
      idx = 0;
      frac = 0;
    end else if (e >= 9000) begin
      idx = 9;
      frac = 0;
    end else begin
      idx = e / 1000;
      frac = e % 1000;
    end
    nxt = (idx < 9) ? idx + 1 : idx;
    c0 = is_meo ? MEO_CM[b][idx] : IGSO_CM[b][idx];
    c1 = is_meo ? MEO_CM[b][nxt] : IGSO_CM[b][nxt];
    return c0 * (1000 - frac) + c1 * frac;
  endfunction

  function automatic mp_word_t predict_correction(input logic [5:0] prn,
                                                  input logic signed [14:0] elev,
                                                  input logic [2:0] bands);
    mp_word_t w;
    int sum;
    sum = 0;
    w.cls = bdsmp_pkg::CLS_OTHER;
    if (igso_mask[prn])
      w.cls = bdsmp_pkg::CLS_IGSO;
    else if (meo_mask[prn])
      w.cls = bdsmp_pkg::CLS_MEO;
    if (w.cls != bdsmp_pkg::CLS_OTHER)
      for (int b = 0; b < 3; b++)
        if (bands[b])
          sum -= band_term(b, w.cls == bdsmp_pkg::CLS_MEO, elev);
    w.corr = sum[bdsmp_pkg::CORR_W-1:0];
    return w;
  endfunction

  always @(posedge clk) begin
    if (hold_req) begin
      hold_cnt = HOLD_LEN;
      hold_req = 0;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    mp_word_t exp_w;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_corr_q.size() == 0) begin
        $display("%0t unexpected word: expected none, got corr %0d class %0d", $time,
                 $signed(out_tdata[bdsmp_pkg::CORR_W-1:0]), out_tuser);
        errors++;
      end else begin
        exp_w = pending_corr_q.pop_front();
        words_checked++;
        if (out_tdata[bdsmp_pkg::CORR_W-1:0] !== exp_w.corr) begin
          $display("%0t correction mismatch: expected %0d, got %0d", $time,
                   exp_w.corr, $signed(out_tdata[bdsmp_pkg::CORR_W-1:0]));
          errors++;
        end
        if (out_tdata[23:bdsmp_pkg::CORR_W] !== '0) begin
          $display("%0t pad bits mismatch: expected 0, got %h", $time,
                   out_tdata[23:bdsmp_pkg::CORR_W]);
          errors++;
        end
        if (out_tuser !== exp_w.cls) begin
          $display("%0t class mismatch: expected %0d, got %0d", $time, exp_w.cls, out_tuser);
          errors++;
        end
      end
    end
  end

  task automatic send_obs(input logic [5:0] prn, input logic [14:0] elev,
                          input logic [2:0] bands);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {bands, elev, prn};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_corr_q.push_back(predict_correction(prn, elev, bands));
    words_sent++;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_corr_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic set_masks(input logic [63:0] igso, input logic [63:0] meo);
    cfg_we <= 1'b1;
    cfg_addr <= bdsmp_pkg::REG_IGSO_MASK;
    cfg_wdata <= igso;
    @(posedge clk);
    igso_mask = igso;
    cfg_addr <= bdsmp_pkg::REG_MEO_MASK;
    cfg_wdata <= meo;
    @(posedge clk);
    meo_mask = meo;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [14:0] rand_elev();
    int e;
    case ($urandom_range(9))
      0: e = $urandom;
      1: e = 1000 * $urandom_range(9) + $urandom_range(2) - 1;
      default: e = $urandom_range(18000) - 9000;
    endcase
    return e[14:0];
  endfunction

  task automatic send_random(input int n);
    for (int i = 0; i < n; i++)
      send_obs(6'($urandom_range(63)), rand_elev(), 3'($urandom_range(7)));
  endtask

  task automatic test_reset_masks();
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    send_random(8);
    drain();
  endtask

  task automatic test_directed();
    logic [63:0] igso;
    logic [63:0] meo;
    igso = BDS2_IGSO | 64'h8000_0000_0000_0001;
    meo = BDS2_MEO | 64'h4000_0000_0000_0040;   // PRN 6 in both: IGSO wins
    set_masks(igso, meo);
    send_obs(6'd6, 15'sd0, 3'b111);
    send_obs(6'd6, -15'sd9000, 3'b111);
    send_obs(6'd6, 15'sd9000, 3'b111);
    send_obs(6'd11, 15'sd0, 3'b111);
    send_obs(6'd11, 15'sd9000, 3'b111);
    send_obs(6'd11, 15'sd8999, 3'b111);
    send_obs(6'd62, 15'sd4500, 3'b001);
    send_obs(6'd63, 15'sd999, 3'b010);
    send_obs(6'd0, 15'sd1000, 3'b100);
    send_obs(6'd8, -15'sd1, 3'b111);
    send_obs(6'd8, 15'h4000, 3'b111);           // most negative code
    send_obs(6'd8, 15'h3FFF, 3'b111);           // most positive code
    send_obs(6'd14, 15'h4000, 3'b101);
    send_obs(6'd14, 15'h3FFF, 3'b110);
    send_obs(6'd13, 15'sd4500, 3'b000);
    send_obs(6'd1, 15'sd4500, 3'b111);
    send_obs(6'd5, 15'sd1234, 3'b111);
    send_obs(6'd16, 15'sd1001, 3'b011);
    send_obs(6'd12, 15'sd7999, 3'b111);
    send_obs(6'd12, 15'sd8000, 3'b111);
    send_obs(6'd10, 15'sd1, 3'b111);
    drain();
  endtask

  task automatic test_mask_extremes();
    set_masks('1, '1);
    send_random(20);
    drain();
    set_masks('0, '1);
    send_random(20);
    drain();
  endtask

  task automatic test_backpressure();
    set_masks(BDS2_IGSO, BDS2_MEO);
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    hold_req = 1;
    repeat (2) @(posedge clk);
    send_random(30);
    drain();
  endtask

  task automatic test_random();
    int tx_pct [4] = '{0, 67, 0, 25};
    int rx_pct [4] = '{0, 0, 67, 25};
    for (int p = 0; p < 4; p++) begin
      if (p == 0)
        set_masks(BDS2_IGSO, BDS2_MEO);
      else
        set_masks({$urandom, $urandom}, {$urandom, $urandom});
      tx_idle_pct = tx_pct[p];
      rx_stall_pct = rx_pct[p];
      send_random(125);
      drain();
    end
    tx_idle_pct = 0;
    rx_stall_pct = 0;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_masks();
    test_directed();
    test_mask_extremes();
    test_backpressure();
    test_random();
    drain();
    $display("Covered %0d words / %0d checked: reset masks, node edges, clamps, overlap,",
             words_sent, words_checked);
    $display("all-ones masks, a %0d-cycle output hold-off and four idle/stall mixes", HOLD_LEN);
    if (errors == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
